// ===== design/angle_bias_kalman_filter_unit_assert.svh =====
// assertion macros used by the kalman filter sequencer
// no dependencies
`ifndef ANGLE_BIAS_KALMAN_FILTER_UNIT_ASSERT_SVH
`define ANGLE_BIAS_KALMAN_FILTER_UNIT_ASSERT_SVH

// implication checked on every clock, muted during reset
`define ABK_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/abk_pkg.sv =====
// shared types, constants and fixed-point helpers of the kalman filter
// no dependencies
package abk_pkg;

    localparam int QW = 32;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE   = 32'sd65536;

    // configuration register indexes
    localparam logic [1:0] REG_QA = 2'd0;
    localparam logic [1:0] REG_QB = 2'd1;
    localparam logic [1:0] REG_R  = 2'd2;
    localparam logic [1:0] REG_DT = 2'd3;

    localparam logic [30:0] RST_QA = 31'd66;
    localparam logic [30:0] RST_QB = 31'd197;
    localparam logic [30:0] RST_R  = 31'd32768;
    localparam logic [30:0] RST_DT = 31'd328;

    typedef struct packed {
        logic signed [31:0] measured_angle;
        logic signed [31:0] gyro_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] bias_estimate;
    } out_item_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,     // latch input sample
        OP_CORR,     // t0 = rate - bias
        OP_M_CORR,   // mul corr*dt
        OP_ANGP,     // angp = angle + prod
        OP_M_P11DT,  // mul cov_bias*dt
        OP_P11DT,    // t1 = prod
        OP_M_CROSS,  // mul (ab+ba)*dt
        OP_ACC1,     // acc = P00 - prod + qa
        OP_M_P11DT2, // mul t1*dt
        OP_P00,      // p00 = sat(acc + prod)
        OP_PRED,     // p01, p10, p11, den, innov
        OP_DIV1,     // k1 = p00 / den
        OP_DIV2,     // k2 = p10 / den
        OP_K2,       // gains settled
        OP_M_K1I,    // mul k1*innov
        OP_ANG,      // angle update
        OP_M_K2I,
        OP_BIAS,
        OP_M_K1P00,
        OP_C00,
        OP_M_K1P01,
        OP_C01,
        OP_M_K2P00,
        OP_C10,
        OP_M_K2P01,
        OP_C11       // cov_bias update, result ready
    } op_t;

    typedef struct packed {
        op_t  op;
    } abk_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic den_pos;
    } abk_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'(S32_MAX))
            return S32_MAX;
        else if (v < 66'(S32_MIN))
            return S32_MIN;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(66'(a) - 66'(b));
    endfunction

endpackage

// ===== design/abk_mul.sv =====
// q16.16 multiplier: registered 32x32 product, then registered round and saturate
// depends on abk_pkg
module abk_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic signed [31:0] q
);
    import abk_pkg::*;

    logic signed [63:0] prod_reg;
    logic               stage_reg;
    logic               done_reg;
    logic signed [31:0] q_reg;
    logic signed [65:0] rnd;

    // round half up then floor shift
    assign rnd = (66'(prod_reg) + 66'sd32768) >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    // product and result hold until the next start
    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= a * b;
        if (stage_reg)
            q_reg <= sat32(rnd);
    end

    assign done = done_reg;
    assign q    = q_reg;
endmodule

// ===== design/abk_div.sv =====
// q16.16 divider: restoring, one quotient bit per cycle, 48-bit quotient
// depends on abk_pkg
module abk_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic signed [31:0] d,
    output logic               done,
    output logic signed [31:0] q
);
    import abk_pkg::*;

    localparam int NB = 48;

    logic [47:0] num_reg;
    logic [31:0] den_reg;
    logic [47:0] quo_reg;
    logic [32:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        neg_reg;
    logic        done_reg;
    logic signed [31:0] q_reg;
    logic [32:0] trial;
    logic [32:0] shifted;
    logic signed [65:0] sq;

    assign shifted = {rem_reg[31:0], num_reg[47]};
    assign trial   = shifted - {1'b0, den_reg};
    assign sq      = neg_reg ? -66'($signed({18'd0, quo_reg}))
                             : 66'($signed({18'd0, quo_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'(NB))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 6'd1;
            end
        end
    end

    // numerator magnitude, its sign and the divisor; numerator is |a| << 16
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {(a[31] ? 32'(-a) : 32'(a)), 16'd0};
            den_reg <= d;
            neg_reg <= a[31];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg && cnt_reg != 6'(NB))
        begin
            num_reg <= {num_reg[46:0], 1'b0};
            if (!trial[32])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
        else if (busy_reg)
            q_reg <= sat32(sq);
    end

    assign done = done_reg;
    assign q    = q_reg;
endmodule

// ===== design/abk_datapath.sv =====
// filter state, configuration registers and shared multiplier and divider
// depends on abk_pkg, abk_mul, abk_div
module abk_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  abk_pkg::abk_cmd_t   cmd,
    input  logic                mul_go,
    input  logic                div_go,
    output abk_pkg::abk_stat_t  stat,
    input  abk_pkg::in_item_t   in_item,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_idx,
    input  logic [30:0]         cfg_val,
    output abk_pkg::out_item_t  out_item
);
    import abk_pkg::*;

    logic [30:0] qa_reg, qb_reg, r_reg, dt_reg;
    logic signed [31:0] ang_reg, bias_reg, c00_reg, cab_reg, cba_reg, c11_reg;
    logic signed [31:0] meas_reg, rate_reg;
    logic signed [31:0] t0_reg, t1_reg, angp_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] den_reg, innov_reg, k1_reg, k2_reg;
    logic signed [34:0] acc_reg;
    logic signed [31:0] ma, mb, dn, mq, dq;
    logic signed [31:0] dt_s;
    logic               mdone, ddone;

    assign dt_s = $signed({1'b0, dt_reg});

    // multiplier operand select
    always_comb
    begin
        ma = t0_reg;
        mb = dt_s;
        unique case (cmd.op)
            OP_M_P11DT:  ma = c11_reg;
            OP_M_CROSS:  ma = qadd(cab_reg, cba_reg);
            OP_M_P11DT2: ma = t1_reg;
            OP_M_K1I:    begin ma = k1_reg; mb = innov_reg; end
            OP_M_K2I:    begin ma = k2_reg; mb = innov_reg; end
            OP_M_K1P00:  begin ma = k1_reg; mb = p00_reg; end
            OP_M_K1P01:  begin ma = k1_reg; mb = p01_reg; end
            OP_M_K2P00:  begin ma = k2_reg; mb = p00_reg; end
            OP_M_K2P01:  begin ma = k2_reg; mb = p01_reg; end
            default:     ma = t0_reg;
        endcase
    end

    assign dn = (cmd.op == OP_DIV2) ? p10_reg : p00_reg;

    abk_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_go), .a(ma), .b(mb), .done(mdone), .q(mq)
    );
    abk_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_go), .a(dn), .d(den_reg), .done(ddone), .q(dq)
    );

    assign stat.mul_done = mdone;
    assign stat.div_done = ddone;
    assign stat.den_pos  = !den_reg[31] && (den_reg != 32'sd0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= RST_QA;
            qb_reg <= RST_QB;
            r_reg  <= RST_R;
            dt_reg <= RST_DT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_QA: qa_reg <= cfg_val;
                REG_QB: qb_reg <= cfg_val;
                REG_R:  r_reg  <= cfg_val;
                REG_DT: dt_reg <= cfg_val;
            endcase
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_reg  <= '0;
            bias_reg <= '0;
            c00_reg  <= Q_ONE;
            cab_reg  <= '0;
            cba_reg  <= '0;
            c11_reg  <= Q_ONE;
        end
        else
        begin
            unique case (cmd.op)
                OP_ANG:  ang_reg  <= qadd(angp_reg, mq);
                OP_BIAS: bias_reg <= qadd(bias_reg, mq);
                OP_C00:  c00_reg  <= qsub(p00_reg, mq);
                OP_C01:  cab_reg  <= qsub(p01_reg, mq);
                OP_C10:  cba_reg  <= qsub(p10_reg, mq);
                OP_C11:  c11_reg  <= qsub(p11_reg, mq);
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                meas_reg <= in_item.measured_angle;
                rate_reg <= in_item.gyro_rate;
                k1_reg   <= '0;
                k2_reg   <= '0;
            end
            OP_CORR:  t0_reg   <= qsub(rate_reg, bias_reg);
            OP_ANGP:  angp_reg <= qadd(ang_reg, mq);
            OP_P11DT: t1_reg   <= mq;
            OP_ACC1:  acc_reg  <= 35'(c00_reg) - 35'(mq) + 35'($signed({1'b0, qa_reg}));
            OP_P00:   p00_reg  <= sat32(66'(acc_reg) + 66'(mq));
            OP_PRED:
            begin
                p01_reg   <= qsub(cab_reg, t1_reg);
                p10_reg   <= qsub(cba_reg, t1_reg);
                p11_reg   <= qadd(c11_reg, $signed({1'b0, qb_reg}));
                den_reg   <= qadd(p00_reg, $signed({1'b0, r_reg}));
                innov_reg <= qsub(meas_reg, angp_reg);
            end
            // gains land when their division finishes
            OP_DIV1:
            begin
                if (ddone)
                    k1_reg <= dq;
            end
            OP_DIV2:
            begin
                if (ddone)
                    k2_reg <= dq;
            end
            default: ;
        endcase
    end

    assign out_item.angle_estimate = ang_reg;
    assign out_item.bias_estimate  = bias_reg;
endmodule

// ===== design/abk_ctrl.sv =====
// sequencer that steps the datapath through predict and update
// depends on abk_pkg and the assertion header
`include "angle_bias_kalman_filter_unit_assert.svh"
module abk_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  abk_pkg::abk_stat_t stat,
    output abk_pkg::abk_cmd_t  cmd,
    output logic               mul_go,
    output logic               div_go,
    output logic               cap_out
);
    import abk_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } state_t;

    state_t state_reg;
    op_t    op_reg;
    op_t    op_next;
    logic   ov_reg;
    logic   go_reg;
    logic   wait_mul;
    logic   wait_div;
    logic   next_wait;
    logic   unit_done;
    logic   in_take;

    function automatic logic is_mul(input op_t o);
        return (o == OP_M_CORR) || (o == OP_M_P11DT) ||
               (o == OP_M_CROSS) || (o == OP_M_P11DT2) ||
               (o == OP_M_K1I) || (o == OP_M_K2I) ||
               (o == OP_M_K1P00) || (o == OP_M_K1P01) ||
               (o == OP_M_K2P00) || (o == OP_M_K2P01);
    endfunction

    function automatic logic is_div(input op_t o);
        return (o == OP_DIV1) || (o == OP_DIV2);
    endfunction

    // step waits on its unit before moving on
    assign wait_mul  = is_mul(op_reg);
    assign wait_div  = is_div(op_reg);
    assign op_next   = op_t'(op_reg + 5'd1);
    assign next_wait = is_mul(op_next) || is_div(op_next);
    assign unit_done = (wait_mul && stat.mul_done) ||
                       (wait_div && (stat.div_done || !stat.den_pos));

    // request is latched on the accepting edge
    assign in_stall  = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign cmd.op    = (state_reg == S_IDLE) ? (in_take ? OP_LOAD : OP_NOP) : op_reg;
    assign mul_go    = go_reg && wait_mul;
    assign div_go    = go_reg && wait_div && stat.den_pos;
    assign cap_out   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NOP;
            ov_reg    <= 1'b0;
            go_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    go_reg <= 1'b0;
                    if (!out_stall)
                        ov_reg <= 1'b0;
                    if (in_take)
                    begin
                        state_reg <= S_RUN;
                        op_reg    <= OP_CORR;
                    end
                end
                S_RUN:
                begin
                    if (op_reg == OP_C11)
                    begin
                        state_reg <= S_IDLE;
                        op_reg    <= OP_NOP;
                        ov_reg    <= 1'b1;
                        go_reg    <= 1'b0;
                    end
                    else
                    begin
                        op_reg <= op_next;
                        go_reg <= next_wait;
                        if (next_wait)
                            state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    // unit started on the first wait cycle
                    if (unit_done)
                    begin
                        op_reg <= op_next;
                        go_reg <= next_wait;
                        if (!next_wait)
                            state_reg <= S_RUN;
                    end
                    else
                        go_reg <= 1'b0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ABK_ASSERT_IMPL(a_busy_stalls, state_reg != S_IDLE, in_stall, "input taken while busy")
    `ABK_ASSERT_NEXT(a_done_valid, state_reg == S_RUN && op_reg == OP_C11, out_valid, "result lost")
    `ABK_ASSERT_IMPL(a_go_onehot, 1'b1, !(mul_go && div_go), "both units started")
endmodule

// ===== design/angle_bias_kalman_filter_unit.sv =====
// top level of the angle and gyro bias kalman filter
// depends on abk_pkg, abk_ctrl, abk_datapath
//
//  port group   direction  handshake              payload
//  in_*         in         in_valid / in_stall    in_item_t
//  out_*        out        out_valid / out_stall  out_item_t
//  cfg_*        in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// per sample the sequencer runs two divider passes for the gains, ten passes
// through the shared multiplier and 13 other steps.
// with a non-positive gain denominator the divisions are skipped; gains stay zero.
// reset returns state and registers to their defaults; no clearing pass.
// a waiting result holds while out_stall is high; the next sample waits too.
module angle_bias_kalman_filter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  abk_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output abk_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data
);
    import abk_pkg::*;

    abk_cmd_t  cmd;
    abk_stat_t stat;
    logic      mul_go, div_go, cap_out;

    assign cfg_ready = 1'b1;

    abk_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd),
        .mul_go(mul_go), .div_go(div_go), .cap_out(cap_out)
    );

    abk_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .mul_go(mul_go), .div_go(div_go),
        .stat(stat), .in_item(in_data), .cfg_we(cfg_valid && cfg_ready && !cap_out),
        .cfg_idx(cfg_index), .cfg_val(cfg_data), .out_item(out_data)
    );
endmodule

// ===== sim/testbench.sv =====
// self-checking testbench of the angle and gyro bias kalman filter unit
// depends on abk_pkg and angle_bias_kalman_filter_unit
module testbench;
    import abk_pkg::*;

    localparam int LATENCY = 200;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1250;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [30:0] cfg_data;

    angle_bias_kalman_filter_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // filter state of the predictor
    logic [30:0] noise_qa, noise_qb, noise_r, step_dt;
    logic signed [31:0] est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

    in_item_t sample_queue[$];
    out_item_t estimate_queue[$];
    int error_count;
    int idle_cycles;
    bit hold_requests;
    logic in_fire;

    always #10 clk = ~clk;

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // q16.16 multiply, round half up
    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b) + 66'sd32768;
        return clamp32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return clamp32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return clamp32(66'(a) - 66'(b));
    endfunction

    // q16.16 divide, truncated toward zero, divisor positive
    function automatic logic signed [31:0] fx_div(input logic signed [31:0] a,
                                                  input logic signed [31:0] d);
        logic signed [65:0] n;
        n = 66'(a) * 66'sd65536;
        return clamp32(n / 66'(d));
    endfunction

    // one filter step; returns the new angle and bias
    function automatic out_item_t filter_step(input in_item_t s);
        logic signed [31:0] dt, corr, ang_p, p11dt, p00, p01, p10, p11, den, k1, k2;
        logic signed [31:0] innov;
        logic signed [65:0] acc;
        out_item_t r;
        dt = {1'b0, step_dt};
        corr = fx_sub(s.gyro_rate, est_bias);
        ang_p = fx_add(est_angle, fx_mul(corr, dt));
        p11dt = fx_mul(p_bb, dt);
        acc = 66'(p_aa) - 66'(fx_mul(fx_add(p_ab, p_ba), dt))
            + 66'(fx_mul(p11dt, dt)) + 66'({1'b0, noise_qa});
        p00 = clamp32(acc);
        p01 = fx_sub(p_ab, p11dt);
        p10 = fx_sub(p_ba, p11dt);
        p11 = fx_add(p_bb, $signed({1'b0, noise_qb}));
        den = fx_add(p00, $signed({1'b0, noise_r}));
        k1 = 0;
        k2 = 0;
        if (den > 0)
        begin
            k1 = fx_div(p00, den);
            k2 = fx_div(p10, den);
        end
        innov = fx_sub(s.measured_angle, ang_p);
        est_angle = fx_add(ang_p, fx_mul(k1, innov));
        est_bias = fx_add(est_bias, fx_mul(k2, innov));
        p_aa = fx_sub(p00, fx_mul(k1, p00));
        p_ab = fx_sub(p01, fx_mul(k1, p01));
        p_ba = fx_sub(p10, fx_mul(k2, p00));
        p_bb = fx_sub(p11, fx_mul(k2, p01));
        r.angle_estimate = est_angle;
        r.bias_estimate = est_bias;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 200);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 2000) - 1000;
            3: return ($urandom_range(0, 200) - 100) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // request driver; in_fire marks a request taken at the last rising edge
    int send_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else if (!in_valid || in_fire)
        begin
            if (in_fire)
                void'(sample_queue.pop_front());
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (sample_queue.size() > 0 && !hold_requests)
            begin
                in_valid <= 1'b1;
                in_data <= sample_queue[0];
                send_gap = (($urandom_range(0, 3) == 0) ? gap_length() : 0);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern
    int stall_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = gap_length();
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
                estimate_queue.push_back(filter_step(in_data));
            if (out_valid && !out_stall)
            begin
                if (estimate_queue.size() == 0)
                    report_mismatch("unexpected result", out_data.angle_estimate, 'x);
                else
                begin
                    if (out_data.angle_estimate !== estimate_queue[0].angle_estimate)
                        report_mismatch("angle", out_data.angle_estimate,
                                        estimate_queue[0].angle_estimate);
                    if (out_data.bias_estimate !== estimate_queue[0].bias_estimate)
                        report_mismatch("bias", out_data.bias_estimate,
                                        estimate_queue[0].bias_estimate);
                    void'(estimate_queue.pop_front());
                end
            end
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("[angle_bias_kalman_filter_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic drain();
        while (sample_queue.size() > 0 || estimate_queue.size() > 0 || in_valid)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // register write on the configuration channel; predictor follows
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_QA: noise_qa = value;
            REG_QB: noise_qb = value;
            REG_R:  noise_r = value;
            REG_DT: step_dt = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_samples(input int count);
        in_item_t s;
        repeat (count)
        begin
            s.measured_angle = rand_word();
            s.gyro_rate = rand_word();
            sample_queue.push_back(s);
        end
    endtask

    task automatic set_regs(input logic [30:0] qa, input logic [30:0] qb,
                            input logic [30:0] r, input logic [30:0] dt);
        write_reg(REG_QA, qa);
        write_reg(REG_QB, qb);
        write_reg(REG_R, r);
        write_reg(REG_DT, dt);
    endtask

    in_item_t directed;
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_QA;
        cfg_data = '0;
        error_count = 0;
        idle_cycles = 0;
        hold_requests = 1'b0;
        noise_qa = RST_QA;
        noise_qb = RST_QB;
        noise_r = RST_R;
        step_dt = RST_DT;
        est_angle = 0;
        est_bias = 0;
        p_aa = Q_ONE;
        p_ab = 0;
        p_ba = 0;
        p_bb = Q_ONE;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes and small values at reset settings
        directed = '{32'sh7FFF_FFFF, 32'sh8000_0000}; sample_queue.push_back(directed);
        directed = '{32'sh8000_0000, 32'sh7FFF_FFFF}; sample_queue.push_back(directed);
        directed = '{32'sd0, 32'sd0}; sample_queue.push_back(directed);
        directed = '{32'shFFFF_FFFF, 32'sd1}; sample_queue.push_back(directed);
        directed = '{32'sd655360, -32'sd65536}; sample_queue.push_back(directed);
        drain();

        // zero registers: non-positive denominator after saturation path
        set_regs(31'd0, 31'd0, 31'd0, 31'd0);
        queue_samples(4);
        drain();
        // large registers drive covariance saturation and negative denominator
        set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_samples(8);
        drain();
        set_regs(31'd1, 31'd1, 31'd1, 31'd1);
        queue_samples(6);
        drain();

        // random phases with varied settings
        for (int ph = 0; ph < 5; ph++)
        begin
            set_regs(31'($urandom_range(0, 2000)), 31'($urandom_range(0, 2000)),
                     (ph == 4) ? 31'($urandom) : 31'($urandom_range(1, 131072)),
                     31'($urandom_range(1, 2000)));
            queue_samples(RANDOM_ITEMS / 10);
            // sender holds off until all results are in
            while (sample_queue.size() > RANDOM_ITEMS / 20)
                @(posedge clk);
            hold_requests = 1'b1;
            while (estimate_queue.size() > 0 || in_valid)
                @(posedge clk);
            hold_requests = 1'b0;
            queue_samples(RANDOM_ITEMS / 10);
            drain();
        end
        set_regs(RST_QA, RST_QB, RST_R, RST_DT);
        queue_samples(50);
        drain();

        if (error_count == 0)
            $display("[angle_bias_kalman_filter_unit] OK");
        else
            $display("[angle_bias_kalman_filter_unit] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/abk_pkg.sv
design/abk_mul.sv
design/abk_div.sv
design/abk_datapath.sv
design/abk_ctrl.sv
design/angle_bias_kalman_filter_unit.sv
sim/testbench.sv
